// File: rtl/ssa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the swap slot allocator.
// No dependencies; every other file of the block but ssa_bitmap uses this package.
package ssa_pkg;

    localparam int SSA_WORD_BITS  = 64;
    localparam int SSA_BIT_W      = 6;
    localparam int SSA_SLOT_W     = 10;
    localparam int SSA_SECTOR_W   = 13;
    localparam int SSA_ADDR_W     = 32;
    localparam int SSA_COUNT_W    = 11;
    localparam int SSA_CNT_W      = 7;
    localparam int SSA_APB_AW     = 3;
    localparam int SSA_APB_DW     = 32;

    localparam logic [SSA_COUNT_W-1:0] SSA_SLOT_COUNT_RST = 11'd1024;
    localparam logic                   SSA_REG_SLOT_COUNT = 1'b0;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_UNUSED = 2'd2
    } t_status;

    typedef struct packed {
        t_status                  status;
        logic [SSA_SLOT_W-1:0]    slot;
        logic [SSA_SECTOR_W-1:0]  sector;
        logic [SSA_ADDR_W-1:0]    addr;
        logic                     is_write;
        logic [SSA_CNT_W-1:0]     count;
    } t_emit_cmd;

endpackage

// File: rtl/ssa_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the swap slot allocator.
// Depends on ssa_pkg for field widths and the status type.
interface ssa_req_if;
    logic                             valid;
    logic                             ready;
    logic                             func;
    logic [ssa_pkg::SSA_ADDR_W-1:0]   page_addr;
    logic [ssa_pkg::SSA_SLOT_W-1:0]   slot_index;

    modport src (output valid, func, page_addr, slot_index, input ready);
    modport snk (input valid, func, page_addr, slot_index, output ready);
    modport mon (input valid, ready, func, page_addr, slot_index);
endinterface

interface ssa_rsp_if;
    logic                             valid;
    logic                             ready;
    ssa_pkg::t_status                 status;
    logic [ssa_pkg::SSA_SLOT_W-1:0]   slot;
    logic [ssa_pkg::SSA_SECTOR_W-1:0] sector;
    logic [ssa_pkg::SSA_ADDR_W-1:0]   mem_addr;
    logic                             is_write;
    logic                             last;

    modport src (output valid, status, slot, sector, mem_addr, is_write, last, input ready);
    modport snk (input valid, status, slot, sector, mem_addr, is_write, last, output ready);
    modport mon (input valid, ready, status, slot, sector, mem_addr, is_write, last);
endinterface

// File: rtl/ssa_bitmap.sv
`timescale 1ns / 1ps
// Used-slot bitmap memory: one write port and one read port, registered read data.
// Depends on nothing beyond its parameters.
module ssa_bitmap #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/ssa_emit.sv
`timescale 1ns / 1ps
// Sector command generator: steps sector and address once per accepted word.
// Depends on ssa_pkg and ssa_rsp_if.
module ssa_emit #(
    parameter int SECTOR_BYTES = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  ssa_pkg::t_emit_cmd i_cmd,
    output logic               o_busy,
    ssa_rsp_if.src             o_rsp
);
    import ssa_pkg::*;

    logic [SSA_CNT_W-1:0]    r_left;
    t_status                 r_status;
    logic [SSA_SLOT_W-1:0]   r_slot;
    logic [SSA_SECTOR_W-1:0] r_sector;
    logic [SSA_ADDR_W-1:0]   r_addr;
    logic                    r_write;
    logic                    take;

    assign take = o_rsp.valid && o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_start) begin
            r_left <= i_cmd.count;
        end else if (take) begin
            r_left <= r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_status <= i_cmd.status;
            r_slot   <= i_cmd.slot;
            r_sector <= i_cmd.sector;
            r_addr   <= i_cmd.addr;
            r_write  <= i_cmd.is_write;
        end else if (take) begin
            r_sector <= r_sector + 1'b1;
            r_addr   <= r_addr + SSA_ADDR_W'(SECTOR_BYTES);
        end
    end

    assign o_rsp.valid    = (r_left != '0);
    assign o_rsp.status   = r_status;
    assign o_rsp.slot     = r_slot;
    assign o_rsp.sector   = r_sector;
    assign o_rsp.mem_addr = r_addr;
    assign o_rsp.is_write = r_write;
    assign o_rsp.last     = (r_left == SSA_CNT_W'(1));
    assign o_busy         = o_rsp.valid;

endmodule

// File: rtl/ssa_ctrl.sv
`timescale 1ns / 1ps
// Allocation controller: clearing pass, first-fit word scan and bitmap update.
// Depends on ssa_pkg, ssa_req_if and the bitmap memory ports.
module ssa_ctrl #(
    parameter int NUM_SLOTS        = 1024,
    parameter int SECTORS_PER_SLOT = 8,
    localparam int WW     = ssa_pkg::SSA_WORD_BITS,
    localparam int NWORDS = (NUM_SLOTS + WW - 1) / WW,
    localparam int WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ssa_req_if.snk                              i_req,
    input  logic [ssa_pkg::SSA_COUNT_W-1:0]     i_slot_count,
    output logic                                o_mem_rd_en,
    output logic [WAW-1:0]                      o_mem_rd_addr,
    input  logic [WW-1:0]                       i_mem_rd_data,
    output logic                                o_mem_wr_en,
    output logic [WAW-1:0]                      o_mem_wr_addr,
    output logic [WW-1:0]                       o_mem_wr_data,
    output logic                                o_emit_start,
    output ssa_pkg::t_emit_cmd                  o_emit_cmd,
    input  logic                                i_emit_busy
);
    import ssa_pkg::*;

    localparam int BW      = SSA_BIT_W;
    localparam int HW      = $clog2(NWORDS + 1);
    localparam int SLW     = WAW + BW;
    localparam int PW      = SLW + 7;
    localparam int LASTBIT = (NUM_SLOTS - 1) % WW;
    localparam int LW      = ($clog2(NUM_SLOTS + 1) > SSA_COUNT_W) ?
                             $clog2(NUM_SLOTS + 1) : SSA_COUNT_W;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN} t_state;

    t_state                r_state, n_state;
    logic [WAW-1:0]        r_clr, n_clr;
    logic [WAW-1:0]        r_word, n_word;
    logic [HW-1:0]         r_hint, n_hint;
    logic                  r_func;
    logic [SSA_ADDR_W-1:0] r_page;
    logic [SSA_SLOT_W-1:0] r_idx;

    logic                  accept;
    logic [LW-1:0]         lim, lim_m1, last_word;
    logic [WW-1:0]         lim_mask, real_mask, avail, bit_sel, free_sel;
    logic                  found, word_full;
    logic [BW-1:0]         pos;
    logic [SLW-1:0]        slot_sel;
    logic [PW-1:0]         sec_prod;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE) && !i_emit_busy;

    assign lim       = (LW'(i_slot_count) > LW'(NUM_SLOTS)) ? LW'(NUM_SLOTS) : LW'(i_slot_count);
    assign lim_m1    = lim - 1'b1;
    assign last_word = lim_m1 >> BW;

    always_comb begin
        for (int b = 0; b < WW; b++) begin
            lim_mask[b]  = (LW'(r_word) != last_word) || (BW'(b) <= lim_m1[BW-1:0]);
            real_mask[b] = (r_word != WAW'(NWORDS - 1)) || (b <= LASTBIT);
        end
    end

    assign avail = ~i_mem_rd_data & lim_mask;
    assign found = |avail;

    always_comb begin
        pos = '0;
        for (int b = WW - 1; b >= 0; b--) begin
            if (avail[b]) begin
                pos = BW'(b);
            end
        end
    end

    assign bit_sel   = WW'(1) << pos;
    assign free_sel  = WW'(1) << r_idx[BW-1:0];
    assign word_full = &(i_mem_rd_data | bit_sel | ~real_mask);
    assign slot_sel  = r_func ? SLW'(r_idx) : {r_word, pos};
    assign sec_prod  = PW'(slot_sel) * PW'(SECTORS_PER_SLOT);

    always_comb begin
        n_state       = r_state;
        n_clr         = r_clr;
        n_word        = r_word;
        n_hint        = r_hint;
        o_mem_rd_en   = 1'b0;
        o_mem_rd_addr = r_word;
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_word;
        o_mem_wr_data = i_mem_rd_data;
        o_emit_start  = 1'b0;
        o_emit_cmd.status   = ST_OK;
        o_emit_cmd.slot     = '0;
        o_emit_cmd.sector   = '0;
        o_emit_cmd.addr     = '0;
        o_emit_cmd.is_write = 1'b0;
        o_emit_cmd.count    = SSA_CNT_W'(1);

        case (r_state)
            S_CLEAR: begin
                o_mem_wr_en   = 1'b1;
                o_mem_wr_addr = r_clr;
                o_mem_wr_data = '0;
                n_clr         = r_clr + 1'b1;
                if (r_clr == WAW'(NWORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (!i_req.func) begin
                        if (lim == '0 || LW'(r_hint) > last_word) begin
                            o_emit_start      = 1'b1;
                            o_emit_cmd.status = ST_FULL;
                        end else begin
                            o_mem_rd_en   = 1'b1;
                            o_mem_rd_addr = r_hint[WAW-1:0];
                            n_word        = r_hint[WAW-1:0];
                            n_state       = S_SCAN;
                        end
                    end else begin
                        if (LW'(i_req.slot_index) >= LW'(NUM_SLOTS)) begin
                            o_emit_start      = 1'b1;
                            o_emit_cmd.status = ST_UNUSED;
                            o_emit_cmd.slot   = i_req.slot_index;
                        end else begin
                            o_mem_rd_en   = 1'b1;
                            o_mem_rd_addr = WAW'(i_req.slot_index >> BW);
                            n_word        = WAW'(i_req.slot_index >> BW);
                            n_state       = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                n_state = S_IDLE;
                if (!r_func) begin
                    if (word_full && HW'(r_word) == r_hint) begin
                        n_hint = r_hint + 1'b1;
                    end
                    if (found) begin
                        o_mem_wr_en         = 1'b1;
                        o_mem_wr_data       = i_mem_rd_data | bit_sel;
                        o_emit_start        = 1'b1;
                        o_emit_cmd.slot     = SSA_SLOT_W'(slot_sel);
                        o_emit_cmd.sector   = sec_prod[SSA_SECTOR_W-1:0];
                        o_emit_cmd.addr     = r_page;
                        o_emit_cmd.is_write = 1'b1;
                        o_emit_cmd.count    = SSA_CNT_W'(SECTORS_PER_SLOT);
                    end else if (LW'(r_word) == last_word) begin
                        o_emit_start      = 1'b1;
                        o_emit_cmd.status = ST_FULL;
                    end else begin
                        o_mem_rd_en   = 1'b1;
                        o_mem_rd_addr = r_word + 1'b1;
                        n_word        = r_word + 1'b1;
                        n_state       = S_SCAN;
                    end
                end else begin
                    if (|(i_mem_rd_data & free_sel)) begin
                        o_mem_wr_en       = 1'b1;
                        o_mem_wr_data     = i_mem_rd_data & ~free_sel;
                        o_emit_start      = 1'b1;
                        o_emit_cmd.slot   = r_idx;
                        o_emit_cmd.sector = sec_prod[SSA_SECTOR_W-1:0];
                        o_emit_cmd.addr   = r_page;
                        o_emit_cmd.count  = SSA_CNT_W'(SECTORS_PER_SLOT);
                        if (HW'(r_word) < r_hint) begin
                            n_hint = HW'(r_word);
                        end
                    end else begin
                        o_emit_start      = 1'b1;
                        o_emit_cmd.status = ST_UNUSED;
                        o_emit_cmd.slot   = r_idx;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_word  <= '0;
            r_hint  <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_word  <= n_word;
            r_hint  <= n_hint;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_req.func;
            r_page <= i_req.page_addr;
            r_idx  <= i_req.slot_index;
        end
    end

endmodule

// File: rtl/swap_slot_allocator.sv
`timescale 1ns / 1ps
// Top level of the swap slot allocator: APB register, controller, bitmap and emitter.
// Depends on ssa_pkg, ssa_if, ssa_bitmap, ssa_ctrl and ssa_emit.
//
// The used-slot bitmap lives in a synchronous memory of 64-bit words, and after reset
// the block clears every word of it before its request ready rises. A free reads and
// checks the bitmap word of its slot and then emits SECTORS_PER_SLOT sector words; an
// error or full answer is a single word. An allocate reads one bitmap word per cycle,
// starting at the lowest word that may still hold a free slot, until it finds a free
// bit or reaches the last word, and then the SECTORS_PER_SLOT write words follow.
// Items are handled one at a time; a new request is taken once the last word of the
// previous one has been accepted. slot_count may be written over APB only while the
// block is idle.
module swap_slot_allocator #(
    parameter int NUM_SLOTS        = 1024,
    parameter int SECTORS_PER_SLOT = 8,
    parameter int SECTOR_BYTES     = 512
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ssa_pkg::SSA_APB_AW-1:0]     paddr,
    input  logic [ssa_pkg::SSA_APB_DW-1:0]     pwdata,
    output logic [ssa_pkg::SSA_APB_DW-1:0]     prdata,
    output logic                               pready,
    ssa_req_if.snk                             i_req,
    ssa_rsp_if.src                             o_rsp
);
    import ssa_pkg::*;

    localparam int WW     = SSA_WORD_BITS;
    localparam int NWORDS = (NUM_SLOTS + WW - 1) / WW;
    localparam int WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;

    logic [SSA_COUNT_W-1:0] r_slot_count;
    logic                   reg_hit;

    logic                   mem_rd_en;
    logic [WAW-1:0]         mem_rd_addr;
    logic [WW-1:0]          mem_rd_data;
    logic                   mem_wr_en;
    logic [WAW-1:0]         mem_wr_addr;
    logic [WW-1:0]          mem_wr_data;
    logic                   emit_start;
    t_emit_cmd              emit_cmd;
    logic                   emit_busy;

    assign reg_hit = (paddr[SSA_APB_AW-1:2] == SSA_REG_SLOT_COUNT);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? SSA_APB_DW'(r_slot_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= SSA_SLOT_COUNT_RST;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_slot_count <= pwdata[SSA_COUNT_W-1:0];
        end
    end

    ssa_ctrl #(
        .NUM_SLOTS        (NUM_SLOTS),
        .SECTORS_PER_SLOT (SECTORS_PER_SLOT)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (i_req),
        .i_slot_count  (r_slot_count),
        .o_mem_rd_en   (mem_rd_en),
        .o_mem_rd_addr (mem_rd_addr),
        .i_mem_rd_data (mem_rd_data),
        .o_mem_wr_en   (mem_wr_en),
        .o_mem_wr_addr (mem_wr_addr),
        .o_mem_wr_data (mem_wr_data),
        .o_emit_start  (emit_start),
        .o_emit_cmd    (emit_cmd),
        .i_emit_busy   (emit_busy)
    );

    ssa_bitmap #(
        .DEPTH (NWORDS),
        .WIDTH (WW),
        .AW    (WAW)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    ssa_emit #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (emit_start),
        .i_cmd   (emit_cmd),
        .o_busy  (emit_busy),
        .o_rsp   (o_rsp)
    );

endmodule

// File: rtl/ssa_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the swap slot allocator, bound to the top level.
// Depends on ssa_pkg and swap_slot_allocator.
module ssa_checker #(
    parameter int SECTOR_BYTES = 512
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_req_valid,
    input  logic                               i_req_ready,
    input  logic                               i_rsp_valid,
    input  logic                               i_rsp_ready,
    input  ssa_pkg::t_status                   i_rsp_status,
    input  logic [ssa_pkg::SSA_SECTOR_W-1:0]   i_rsp_sector,
    input  logic [ssa_pkg::SSA_ADDR_W-1:0]     i_rsp_mem_addr,
    input  logic                               i_rsp_is_write,
    input  logic                               i_rsp_last
);
    import ssa_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_sector)
            && $stable(i_rsp_mem_addr) && $stable(i_rsp_status) && $stable(i_rsp_last))
        else $error("response word changed while stalled");

    a_sector_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_ready && !i_rsp_last |=> i_rsp_valid
            && i_rsp_sector == SSA_SECTOR_W'($past(i_rsp_sector) + 1'b1)
            && i_rsp_mem_addr == SSA_ADDR_W'($past(i_rsp_mem_addr) + SSA_ADDR_W'(SECTOR_BYTES)))
        else $error("sector command did not step by one sector");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != ST_OK |-> i_rsp_last && i_rsp_sector == '0
            && i_rsp_mem_addr == '0 && !i_rsp_is_write)
        else $error("error answer is not a single empty word");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_ready |-> !i_rsp_valid)
        else $error("request taken while a response is still pending");

endmodule

bind swap_slot_allocator ssa_checker #(
    .SECTOR_BYTES (SECTOR_BYTES)
) u_ssa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_status   (o_rsp.status),
    .i_rsp_sector   (o_rsp.sector),
    .i_rsp_mem_addr (o_rsp.mem_addr),
    .i_rsp_is_write (o_rsp.is_write),
    .i_rsp_last     (o_rsp.last)
);
